FILE: design/imu_fuzz_deadzone_filter_core_defines.svh
// Assertion macros for the IMU fuzz and deadzone filter core
`ifndef IMU_FUZZ_DEADZONE_FILTER_CORE_DEFINES_SVH
`define IMU_FUZZ_DEADZONE_FILTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define IFDF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("imu filter check failed");

// next-cycle implication, sampled on aclk, off while in reset
`define IFDF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("imu filter check failed");

`endif

FILE: design/ifdf_pkg.sv
// Shared types, codes and constants of the IMU fuzz and deadzone filter
`timescale 1ns / 1ps

package ifdf_pkg;

    localparam int REPORT_FIELDS = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FUZZ      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_FUZZ     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_DEADZONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_NEAR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FAR      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_RELOAD = 3'd6;

    localparam logic [9:0]  ACCEL_GAIN_RST      = 10'd384;
    localparam logic [11:0] ACCEL_FUZZ_RST      = 12'd12;
    localparam logic [11:0] ORIENT_FUZZ_RST     = 12'd24;
    localparam logic [11:0] GYRO_DEADZONE_RST   = 12'd24;
    localparam logic [8:0]  WEIGHT_NEAR_RST     = 9'd192;
    localparam logic [8:0]  WEIGHT_FAR_RST      = 9'd154;
    localparam logic [11:0] COOLDOWN_RELOAD_RST = 12'd1000;

    localparam logic [8:0] WEIGHT_ONE = 9'd256;

    localparam logic KIND_MOTION   = 1'b0;
    localparam logic KIND_REENABLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_SCALE,
        ST_DECIDE,
        ST_MULT,
        ST_WRITE,
        ST_ZERO
    } state_t;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_BLEND,
        MODE_JUMP
    } mode_t;

    typedef struct packed {
        logic decide;
        logic mult;
        logic write;
    } lane_ctl_t;

    typedef struct packed {
        logic motion_write;
        logic req_load;
    } merge_ctl_t;

    function automatic logic [8:0] clamp_weight(input logic [8:0] w);
        return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
    endfunction

endpackage

FILE: design/imu_fuzz_deadzone_filter_core.sv
// Top level of the IMU fuzz and deadzone filter: sequencer, gain, lanes, merge
//
//  channel   dir  payload
//  cfg_*     in   register index and write data, no handshake
//  s_*       in   one raw motion report per word (ten samples)
//  m_*       out  one motion update or re-enable request per word
//
// A report passes the sequencer states accept, gain multiply, scale and saturate,
// band decision, blend multiply and write, in that order, before the next is accepted.
// An all-zero report passes accept, gain and cooldown count instead.
// The write and request stages wait while the output word register is full and not taken.
// Reset clears the held values and sets the cooldown count and the registers to defaults.
`timescale 1ns / 1ps
`include "imu_fuzz_deadzone_filter_core_defines.svh"

module imu_fuzz_deadzone_filter_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [ifdf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ifdf_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // raw_accel_x, raw_accel_y, raw_accel_z, raw_gyro_x, raw_gyro_y,
    // raw_gyro_z, raw_orient_w, raw_orient_x, raw_orient_y, raw_orient_z
    input  logic [((ifdf_pkg::REPORT_FIELDS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // out_accel_x, out_accel_y, out_accel_z, out_gyro_x, out_gyro_y,
    // out_gyro_z, out_orient_w, out_orient_x, out_orient_y, out_orient_z
    output logic [((ifdf_pkg::REPORT_FIELDS*(SAMPLE_BITS+FRAC_BITS+1)+7)/8)*8-1:0] m_tdata,
    // event_kind
    output logic [0:0]                            m_tuser
);
    import ifdf_pkg::*;

    localparam int RAW_W = REPORT_FIELDS * SAMPLE_BITS;
    localparam int AH_W  = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int OH_W  = SAMPLE_BITS + FRAC_BITS;
    localparam int PW    = SAMPLE_BITS + 11;
    localparam int SW    = PW + FRAC_BITS;
    localparam logic signed [SW-1:0] ACC_LIM = SW'(3) << (SAMPLE_BITS - 2 + FRAC_BITS);

    logic [9:0]  accel_gain_reg;
    logic [11:0] accel_fuzz_reg;
    logic [11:0] orient_fuzz_reg;
    logic [11:0] gyro_deadzone_reg;
    logic [8:0]  weight_near_reg;
    logic [8:0]  weight_far_reg;
    logic [11:0] cooldown_reload_reg;

    state_t      state_reg;
    state_t      state_next;
    logic [11:0] cooldown_reg;
    logic [11:0] cooldown_next;

    logic [RAW_W-1:0]         raw_reg;
    logic signed [SAMPLE_BITS-1:0] samp [REPORT_FIELDS];
    logic                     all_zero;
    logic signed [PW-1:0]     prod_reg [3];
    logic signed [SW-1:0]     shifted [3];
    logic signed [AH_W-1:0]   scale_next [3];
    logic signed [AH_W-1:0]   scale_reg [3];
    logic signed [OH_W-1:0]   orient_cur [4];
    logic signed [OH_W-1:0]   gyro_cur [3];

    logic signed [AH_W-1:0]   accel_new [3];
    logic signed [OH_W-1:0]   orient_new [4];
    logic signed [OH_W-1:0]   gyro_new [3];
    logic [REPORT_FIELDS-1:0] changed;

    lane_ctl_t  lane_ctl;
    merge_ctl_t merge_ctl;
    logic       out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_gain_reg      <= ACCEL_GAIN_RST;
            accel_fuzz_reg      <= ACCEL_FUZZ_RST;
            orient_fuzz_reg     <= ORIENT_FUZZ_RST;
            gyro_deadzone_reg   <= GYRO_DEADZONE_RST;
            weight_near_reg     <= WEIGHT_NEAR_RST;
            weight_far_reg      <= WEIGHT_FAR_RST;
            cooldown_reload_reg <= COOLDOWN_RELOAD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ACCEL_GAIN:      accel_gain_reg      <= cfg_wdata[9:0];
                REG_ACCEL_FUZZ:      accel_fuzz_reg      <= cfg_wdata[11:0];
                REG_ORIENT_FUZZ:     orient_fuzz_reg     <= cfg_wdata[11:0];
                REG_GYRO_DEADZONE:   gyro_deadzone_reg   <= cfg_wdata[11:0];
                REG_WEIGHT_NEAR:     weight_near_reg     <= cfg_wdata[8:0];
                REG_WEIGHT_FAR:      weight_far_reg      <= cfg_wdata[8:0];
                REG_COOLDOWN_RELOAD: cooldown_reload_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < REPORT_FIELDS; i++) begin : g_samp
        assign samp[i] = $signed(raw_reg[i*SAMPLE_BITS +: SAMPLE_BITS]);
    end

    assign all_zero = (raw_reg == '0);

    for (genvar i = 0; i < 4; i++) begin : g_ocur
        assign orient_cur[i] = $signed({samp[6+i], {FRAC_BITS{1'b0}}});
    end

    for (genvar i = 0; i < 3; i++) begin : g_gcur
        assign gyro_cur[i] = $signed({samp[3+i], {FRAC_BITS{1'b0}}});
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            shifted[i] = (SW'(prod_reg[i]) <<< FRAC_BITS) >>> 8;
            priority if (shifted[i] > ACC_LIM) begin
                scale_next[i] = AH_W'(ACC_LIM);
            end else if (shifted[i] < -ACC_LIM) begin
                scale_next[i] = AH_W'(-ACC_LIM);
            end else begin
                scale_next[i] = AH_W'(shifted[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            raw_reg <= s_tdata[RAW_W-1:0];
        end
        if (state_reg == ST_GAIN) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= PW'(samp[i]) * PW'($signed({1'b0, accel_gain_reg}));
            end
        end
        if (state_reg == ST_SCALE) begin
            for (int i = 0; i < 3; i++) begin
                scale_reg[i] <= scale_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cooldown_reg <= COOLDOWN_RELOAD_RST;
        end else begin
            state_reg    <= state_next;
            cooldown_reg <= cooldown_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cooldown_next = cooldown_reg;
        s_tready      = 1'b0;
        lane_ctl      = '0;
        merge_ctl     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                state_next = all_zero ? ST_ZERO : ST_SCALE;
            end
            ST_SCALE: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                lane_ctl.decide = 1'b1;
                state_next      = ST_MULT;
            end
            ST_MULT: begin
                lane_ctl.mult = 1'b1;
                state_next    = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    lane_ctl.write         = 1'b1;
                    merge_ctl.motion_write = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            ST_ZERO: begin
                if (cooldown_reg <= 12'd1) begin
                    if (out_free) begin
                        merge_ctl.req_load = 1'b1;
                        cooldown_next      = cooldown_reload_reg;
                        state_next         = ST_IDLE;
                    end
                end else begin
                    cooldown_next = cooldown_reg - 12'd1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    for (genvar i = 0; i < 3; i++) begin : g_accel
        ifdf_fuzz_lane #(
            .HELD_W    (AH_W),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (lane_ctl),
            .cur         (scale_reg[i]),
            .band        (accel_fuzz_reg),
            .weight_near (weight_near_reg),
            .weight_far  (weight_far_reg),
            .held_new    (accel_new[i]),
            .changed     (changed[i])
        );
    end

    for (genvar i = 0; i < 4; i++) begin : g_orient
        ifdf_fuzz_lane #(
            .HELD_W    (OH_W),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (lane_ctl),
            .cur         (orient_cur[i]),
            .band        (orient_fuzz_reg),
            .weight_near (weight_near_reg),
            .weight_far  (weight_far_reg),
            .held_new    (orient_new[i]),
            .changed     (changed[3+i])
        );
    end

    for (genvar i = 0; i < 3; i++) begin : g_gyro
        ifdf_dead_lane #(
            .HELD_W    (OH_W),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (lane_ctl),
            .cur      (gyro_cur[i]),
            .deadzone (gyro_deadzone_reg),
            .held_new (gyro_new[i]),
            .changed  (changed[7+i])
        );
    end

    ifdf_merge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (merge_ctl),
        .accel_new  (accel_new),
        .orient_new (orient_new),
        .gyro_new   (gyro_new),
        .changed    (changed),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .free       (out_free)
    );

    `IFDF_ASSERT_IMP(a_req_word_zero, m_tvalid && m_tuser[0], m_tdata == '0)
    `IFDF_ASSERT_NXT(a_one_report, s_tvalid && s_tready, !s_tready)
    `IFDF_ASSERT_IMP(a_write_has_room, lane_ctl.write || merge_ctl.req_load, out_free)

endmodule

FILE: design/ifdf_fuzz_lane.sv
// One fuzz filter lane: band decision, weighted blend, held value
`timescale 1ns / 1ps

module ifdf_fuzz_lane #(
    parameter int HELD_W    = 25,
    parameter int FRAC_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ifdf_pkg::lane_ctl_t      ctl,
    input  logic signed [HELD_W-1:0] cur,
    input  logic [11:0]              band,
    input  logic [8:0]               weight_near,
    input  logic [8:0]               weight_far,
    output logic signed [HELD_W-1:0] held_new,
    output logic                     changed
);
    import ifdf_pkg::*;

    localparam int DW   = HELD_W + 1;
    localparam int BW   = 12 + FRAC_BITS;
    localparam int CMPW = ((DW > BW) ? DW : BW) + 2;
    localparam int PRW  = DW + 10;
    localparam logic signed [PRW-1:0] ROUND = PRW'(128);

    logic signed [HELD_W-1:0] held_reg;
    mode_t                    mode_reg;
    mode_t                    mode_next;
    logic signed [DW-1:0]     diff_reg;
    logic signed [DW-1:0]     diff;
    logic [DW-1:0]            mag;
    logic [CMPW-1:0]          mag_c;
    logic [CMPW-1:0]          band_c;
    logic [8:0]               inv_reg;
    logic [8:0]               inv_next;
    logic signed [PRW-1:0]    prod_reg;
    logic signed [PRW-1:0]    step;
    logic signed [HELD_W-1:0] blend;

    always_comb begin
        diff   = DW'(cur) - DW'(held_reg);
        mag    = diff[DW-1] ? DW'(-diff) : DW'(diff);
        mag_c  = CMPW'(mag);
        band_c = CMPW'({band, {FRAC_BITS{1'b0}}});
        mode_next = MODE_JUMP;
        inv_next  = '0;
        priority if ((mag_c << 1) < band_c) begin
            mode_next = MODE_HOLD;
        end else if (mag_c < band_c) begin
            mode_next = MODE_BLEND;
            inv_next  = WEIGHT_ONE - clamp_weight(weight_near);
        end else if (mag_c < (band_c << 1)) begin
            mode_next = MODE_BLEND;
            inv_next  = WEIGHT_ONE - clamp_weight(weight_far);
        end else begin
            mode_next = MODE_JUMP;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.decide) begin
            mode_reg <= mode_next;
            diff_reg <= diff;
            inv_reg  <= inv_next;
        end
        if (ctl.mult) begin
            prod_reg <= PRW'($signed({1'b0, inv_reg})) * PRW'(diff_reg);
        end
    end

    always_comb begin
        step  = (prod_reg + ROUND) >>> 8;
        blend = HELD_W'(PRW'(held_reg) + step);
        unique case (mode_reg)
            MODE_HOLD:  held_new = held_reg;
            MODE_BLEND: held_new = blend;
            MODE_JUMP:  held_new = cur;
            default:    held_new = held_reg;
        endcase
        changed = (mode_reg != MODE_HOLD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (ctl.write) begin
            held_reg <= held_new;
        end
    end

endmodule

FILE: design/ifdf_dead_lane.sv
// One gyro lane: graded deadzone and held value
`timescale 1ns / 1ps

module ifdf_dead_lane #(
    parameter int HELD_W    = 24,
    parameter int FRAC_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ifdf_pkg::lane_ctl_t      ctl,
    input  logic signed [HELD_W-1:0] cur,
    input  logic [11:0]              deadzone,
    output logic signed [HELD_W-1:0] held_new,
    output logic                     changed
);
    import ifdf_pkg::*;

    localparam int DZW  = 12 + FRAC_BITS;
    localparam int CMPW = ((HELD_W > DZW) ? HELD_W : DZW) + 3;

    logic signed [HELD_W-1:0] held_reg;
    logic signed [HELD_W-1:0] nxt_reg;
    logic signed [HELD_W-1:0] nxt_next;
    logic [HELD_W-1:0]        mag;
    logic [CMPW-1:0]          mag_c;
    logic [CMPW-1:0]          dz_c;

    always_comb begin
        mag   = cur[HELD_W-1] ? HELD_W'(-cur) : HELD_W'(cur);
        mag_c = CMPW'(mag);
        dz_c  = CMPW'({deadzone, {FRAC_BITS{1'b0}}});
        priority if (mag_c < dz_c) begin
            nxt_next = '0;
        end else if (mag_c < (dz_c << 1)) begin
            nxt_next = cur >>> 2;
        end else if (mag_c < (dz_c << 2)) begin
            nxt_next = cur >>> 1;
        end else begin
            nxt_next = cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.decide) begin
            nxt_reg <= nxt_next;
        end
    end

    assign held_new = nxt_reg;
    assign changed  = (nxt_reg != held_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (ctl.write) begin
            held_reg <= nxt_reg;
        end
    end

endmodule

FILE: design/ifdf_merge.sv
// Merge stage: combine lane results and drive the output word register
`timescale 1ns / 1ps

module ifdf_merge #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  ifdf_pkg::merge_ctl_t                       ctl,
    input  logic signed [SAMPLE_BITS+FRAC_BITS:0]      accel_new [3],
    input  logic signed [SAMPLE_BITS+FRAC_BITS-1:0]    orient_new [4],
    input  logic signed [SAMPLE_BITS+FRAC_BITS-1:0]    gyro_new [3],
    input  logic [ifdf_pkg::REPORT_FIELDS-1:0]         changed,
    input  logic                                       m_tready,
    output logic                                       m_tvalid,
    output logic [((ifdf_pkg::REPORT_FIELDS*(SAMPLE_BITS+FRAC_BITS+1)+7)/8)*8-1:0] m_tdata,
    output logic [0:0]                                 m_tuser,
    output logic                                       free
);
    import ifdf_pkg::*;

    localparam int OUT_FW = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int OUT_W  = ((REPORT_FIELDS * OUT_FW + 7) / 8) * 8;

    logic signed [OUT_FW-1:0] fld [REPORT_FIELDS];
    logic [OUT_W-1:0]         data_next;
    logic                     load_motion;
    logic                     valid_reg;
    logic [OUT_W-1:0]         data_reg;
    logic                     user_reg;

    always_comb begin
        fld[0] = OUT_FW'(accel_new[0]);
        fld[1] = OUT_FW'(accel_new[1]);
        fld[2] = -OUT_FW'(accel_new[2]);
        fld[3] = OUT_FW'(gyro_new[0]);
        fld[4] = OUT_FW'(gyro_new[1]);
        fld[5] = -OUT_FW'(gyro_new[2]);
        fld[6] = OUT_FW'(orient_new[0]);
        fld[7] = OUT_FW'(orient_new[1]);
        fld[8] = OUT_FW'(orient_new[2]);
        fld[9] = -OUT_FW'(orient_new[3]);
        data_next = '0;
        for (int i = 0; i < REPORT_FIELDS; i++) begin
            data_next[i*OUT_FW +: OUT_FW] = fld[i];
        end
    end

    assign load_motion = ctl.motion_write && (|changed);
    assign free        = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_motion || ctl.req_load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_motion) begin
            data_reg <= data_next;
            user_reg <= KIND_MOTION;
        end else if (ctl.req_load) begin
            data_reg <= '0;
            user_reg <= KIND_REENABLE;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

FILE: tb/sv/imu_fuzz_deadzone_filter_core_tb.sv
// Self-checking stream testbench of the IMU fuzz and deadzone filter core
`timescale 1ns / 1ps

module imu_fuzz_deadzone_filter_core_tb;
    import ifdf_pkg::*;

    localparam int SB    = 16;
    localparam int FB    = 8;
    localparam int S_W   = ((REPORT_FIELDS * SB + 7) / 8) * 8;
    localparam int OUT_W = SB + FB + 1;
    localparam int M_W   = ((REPORT_FIELDS * OUT_W + 7) / 8) * 8;
    localparam longint ACCEL_SAT = 3 * (1 << (SB - 2)) * (1 << FB);

    localparam int STALL_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PRINT_LIMIT    = 100;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic           kind;
        logic [M_W-1:0] data;
    } motion_word_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [S_W-1:0]        s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [M_W-1:0]        m_tdata;
    wire  [0:0]            m_tuser;

    imu_fuzz_deadzone_filter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // filter settings and held values as the block should hold them
    logic [9:0]  gain_r;
    logic [11:0] afuzz_r;
    logic [11:0] ofuzz_r;
    logic [11:0] dzone_r;
    logic [8:0]  wnear_r;
    logic [8:0]  wfar_r;
    logic [11:0] reload_r;
    longint      accel_hold [3];
    longint      orient_hold [4];
    longint      gyro_hold [3];
    int          cool_left;

    logic [S_W-1:0] report_q [$];
    motion_word_t   predicted_words [$];
    motion_word_t   head_word;
    bit             word_bad;
    logic [15:0]    last_smp [10];

    int send_idle_pct = 20;
    int recv_idle_pct = 20;
    int stall_gen     = 0;
    int stall_seen;
    int hold_left;
    int idle_cycles;
    int fail_count    = 0;
    int word_count    = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint floor_q8(input longint v);
        longint q;
        q = v / 256;
        if ((v % 256) != 0 && v < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint abs_l(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint eff_weight(input logic [8:0] w);
        return (w > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(w);
    endfunction

    task automatic fuzz_update(input longint cur, inout longint held,
                               input logic [11:0] band_raw, inout bit chg);
        longint band;
        longint d;
        longint w;
        band = longint'(band_raw) * (1 << FB);
        d = abs_l(cur - held);
        if (2 * d < band) return;
        if (d < band) begin
            w = eff_weight(wnear_r);
        end else if (d < 2 * band) begin
            w = eff_weight(wfar_r);
        end else begin
            held = cur;
            chg = 1'b1;
            return;
        end
        held = floor_q8(w * held + (256 - w) * cur + 128);
        chg = 1'b1;
    endtask

    task automatic gyro_update(input longint cur, inout longint held, inout bit chg);
        longint dz;
        longint a;
        longint nxt;
        dz = longint'(dzone_r) * (1 << FB);
        a = abs_l(cur);
        if (a < dz) nxt = 0;
        else if (a < 2 * dz) nxt = cur / 4;
        else if (a < 4 * dz) nxt = cur / 2;
        else nxt = cur;
        if (nxt != held) begin
            held = nxt;
            chg = 1'b1;
        end
    endtask

    task automatic filter_report(input logic [S_W-1:0] rpt);
        longint         smp [10];
        longint         v [10];
        longint         a;
        bit             zero_rpt;
        bit             chg;
        logic [M_W-1:0] dat;
        motion_word_t   w;
        zero_rpt = 1'b1;
        chg = 1'b0;
        for (int i = 0; i < REPORT_FIELDS; i++) begin
            smp[i] = longint'($signed(rpt[i*SB +: SB]));
            if (smp[i] != 0) zero_rpt = 1'b0;
        end
        if (zero_rpt) begin
            if (cool_left <= 1) begin
                cool_left = int'(reload_r);
                w.kind = KIND_REENABLE;
                w.data = '0;
                predicted_words.push_back(w);
            end else begin
                cool_left = cool_left - 1;
            end
            return;
        end
        for (int i = 0; i < 3; i++) begin
            a = floor_q8(smp[i] * longint'(gain_r) * (1 << FB));
            if (a > ACCEL_SAT) a = ACCEL_SAT;
            if (a < -ACCEL_SAT) a = -ACCEL_SAT;
            fuzz_update(a, accel_hold[i], afuzz_r, chg);
        end
        for (int i = 0; i < 4; i++)
            fuzz_update(smp[6+i] * (1 << FB), orient_hold[i], ofuzz_r, chg);
        for (int i = 0; i < 3; i++)
            gyro_update(smp[3+i] * (1 << FB), gyro_hold[i], chg);
        if (!chg) return;
        v[0] = accel_hold[0];
        v[1] = accel_hold[1];
        v[2] = -accel_hold[2];
        v[3] = gyro_hold[0];
        v[4] = gyro_hold[1];
        v[5] = -gyro_hold[2];
        v[6] = orient_hold[0];
        v[7] = orient_hold[1];
        v[8] = orient_hold[2];
        v[9] = -orient_hold[3];
        dat = '0;
        for (int i = 0; i < REPORT_FIELDS; i++)
            dat[i*OUT_W +: OUT_W] = v[i][OUT_W-1:0];
        w.kind = KIND_MOTION;
        w.data = dat;
        predicted_words.push_back(w);
    endtask

    // sender: hold the word until taken, predict on each accepted word
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) filter_report(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (report_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= report_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random backpressure plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            stall_seen <= 0;
        end else if (stall_gen != stall_seen) begin
            stall_seen <= stall_gen;
            hold_left  <= STALL_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            word_count <= word_count + 1;
            word_bad = 1'b0;
            if (predicted_words.size() == 0) begin
                word_bad = 1'b1;
                if (fail_count < PRINT_LIMIT)
                    $display("%0t: word %0d unexpected, expected none, got kind %0d data %h",
                             $time, word_count, m_tuser[0], m_tdata);
            end else begin
                head_word = predicted_words.pop_front();
                if (m_tuser[0] !== head_word.kind) begin
                    word_bad = 1'b1;
                    if (fail_count < PRINT_LIMIT)
                        $display("%0t: word %0d event_kind expected %0d got %0d",
                                 $time, word_count, head_word.kind, m_tuser[0]);
                end
                for (int f = 0; f < REPORT_FIELDS; f++) begin
                    if (m_tdata[f*OUT_W +: OUT_W] !== head_word.data[f*OUT_W +: OUT_W]) begin
                        word_bad = 1'b1;
                        if (fail_count < PRINT_LIMIT)
                            $display("%0t: word %0d field %0d expected %h got %h",
                                     $time, word_count, f,
                                     head_word.data[f*OUT_W +: OUT_W],
                                     m_tdata[f*OUT_W +: OUT_W]);
                    end
                end
            end
            if (word_bad) fail_count <= fail_count + 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("imu_fuzz_deadzone_filter_core_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ACCEL_GAIN:      gain_r   = val[9:0];
            REG_ACCEL_FUZZ:      afuzz_r  = val;
            REG_ORIENT_FUZZ:     ofuzz_r  = val;
            REG_GYRO_DEADZONE:   dzone_r  = val;
            REG_WEIGHT_NEAR:     wnear_r  = val[8:0];
            REG_WEIGHT_FAR:      wfar_r   = val[8:0];
            REG_COOLDOWN_RELOAD: reload_r = val;
            default: ;
        endcase
    endtask

    task automatic set_filter(input logic [11:0] gain, input logic [11:0] afz,
                              input logic [11:0] ofz, input logic [11:0] dz,
                              input logic [11:0] wn, input logic [11:0] wf,
                              input logic [11:0] reload);
        write_reg(REG_ACCEL_GAIN, gain);
        write_reg(REG_ACCEL_FUZZ, afz);
        write_reg(REG_ORIENT_FUZZ, ofz);
        write_reg(REG_GYRO_DEADZONE, dz);
        write_reg(REG_WEIGHT_NEAR, wn);
        write_reg(REG_WEIGHT_FAR, wf);
        write_reg(REG_COOLDOWN_RELOAD, reload);
    endtask

    // advance until every word is sent and every result is back, then let the core settle
    task automatic wait_idle;
        @(negedge aclk);
        while (report_q.size() != 0 || s_tvalid || predicted_words.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [S_W-1:0] pack_report(
        input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
        input logic [15:0] gx, input logic [15:0] gy, input logic [15:0] gz,
        input logic [15:0] ow, input logic [15:0] ox, input logic [15:0] oy,
        input logic [15:0] oz);
        return {oz, oy, ox, ow, gz, gy, gx, az, ay, ax};
    endfunction

    // mostly small steps around the last report so the fuzz bands and deadzone grades get hit
    task automatic push_random(input int count);
        logic [S_W-1:0] rpt;
        logic [15:0]    s;
        int             pick;
        int             span;
        int             t;
        repeat (count) begin
            pick = $urandom_range(99);
            case ($urandom_range(4))
                0: span = 2;
                1: span = 8;
                2: span = 32;
                3: span = 128;
                default: span = 1024;
            endcase
            for (int i = 0; i < REPORT_FIELDS; i++) begin
                if (pick < 8) begin
                    s = '0;
                end else if (pick < 18) begin
                    s = 16'($urandom);
                end else if (pick < 23) begin
                    case ($urandom_range(4))
                        0: s = 16'h8000;
                        1: s = 16'h7FFF;
                        2: s = 16'h0000;
                        3: s = 16'h0001;
                        default: s = 16'hFFFF;
                    endcase
                end else if (pick < 28) begin
                    s = last_smp[i];
                end else if (i >= 3 && i < 6 && $urandom_range(2) == 0) begin
                    t = (1 << $urandom_range(2)) * int'(dzone_r) + $urandom_range(2) - 1;
                    s = 16'($urandom_range(1) ? t : -t);
                end else begin
                    s = 16'(last_smp[i] + $urandom_range(2 * span) - span);
                end
                rpt[i*SB +: SB] = s;
            end
            if (rpt != '0) begin
                for (int i = 0; i < REPORT_FIELDS; i++) last_smp[i] = rpt[i*SB +: SB];
            end
            report_q.push_back(rpt);
        end
    endtask

    task automatic run_phase(input int n_items, input int idle_pct, input bit with_stall);
        send_idle_pct = idle_pct;
        recv_idle_pct = idle_pct;
        push_random(n_items);
        if (with_stall) stall_gen = stall_gen + 1;
        wait_idle();
    endtask

    initial begin
        gain_r    = ACCEL_GAIN_RST;
        afuzz_r   = ACCEL_FUZZ_RST;
        ofuzz_r   = ORIENT_FUZZ_RST;
        dzone_r   = GYRO_DEADZONE_RST;
        wnear_r   = WEIGHT_NEAR_RST;
        wfar_r    = WEIGHT_FAR_RST;
        reload_r  = COOLDOWN_RELOAD_RST;
        cool_left = int'(COOLDOWN_RELOAD_RST);
        for (int i = 0; i < REPORT_FIELDS; i++) last_smp[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words at reset settings: extremes, bands, deadzone grades, zero report
        report_q.push_back(pack_report(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                       16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        report_q.push_back(pack_report(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                       16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        report_q.push_back(pack_report(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                       16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        report_q.push_back(pack_report(1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
        report_q.push_back('0);
        report_q.push_back(pack_report(100, 100, 100, 23, -23, 0, 100, 100, 100, 100));
        report_q.push_back(pack_report(102, 101, 99, 23, -23, 0, 105, 95, 110, 100));
        report_q.push_back(pack_report(105, 94, 106, 24, -24, 47, 115, 85, 120, 88));
        report_q.push_back(pack_report(113, 86, 90, 48, -48, -95, 140, 60, 150, 50));
        report_q.push_back(pack_report(300, -300, 0, 96, -96, 95, 400, -400, 0, -1));
        report_q.push_back(pack_report(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        report_q.push_back(pack_report(16'h7FFF, 16'h8000, 0, 16'h7FFF, 16'h8000, 1,
                                       16'h8000, 16'h7FFF, -1, 16'h8000));
        report_q.push_back(pack_report(16'h7FFF, 16'h8000, 0, 16'h7FFF, 16'h8000, 1,
                                       16'h8000, 16'h7FFF, -1, 16'h8000));
        wait_idle();

        // drain the reset cooldown count, then every zero report asks for re-enable
        write_reg(REG_COOLDOWN_RELOAD, 12'd0);
        repeat (1000) report_q.push_back('0);
        wait_idle();

        set_filter(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        run_phase(75, 20, 1'b1);
        set_filter(12'hFFF, 12'd4095, 12'd4095, 12'd4095, 12'hFFF, 12'h100, 12'd1);
        run_phase(75, 20, 1'b0);
        set_filter(12'd256, 12'd8, 12'd16, 12'd16, 12'h1FF, 12'd300, 12'd3);
        run_phase(75, 0, 1'b0);
        write_reg(REG_UNUSED, 12'hABC);
        set_filter(12'd384, 12'd12, 12'd24, 12'd24, 12'd192, 12'd154, 12'd2);
        run_phase(75, 20, 1'b1);
        repeat (3) begin
            set_filter(12'($urandom_range(1023)), 12'($urandom_range(48)),
                       12'($urandom_range(96)), 12'($urandom_range(64)),
                       12'($urandom_range(320)), 12'($urandom_range(320)),
                       12'($urandom_range(5)));
            run_phase(75, 20, 1'b0);
        end
        set_filter(12'($urandom_range(1023)), 12'($urandom_range(48)),
                   12'($urandom_range(96)), 12'($urandom_range(64)),
                   12'($urandom_range(256)), 12'($urandom_range(256)), 12'd4095);
        run_phase(75, 20, 1'b0);

        repeat (2 * DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && predicted_words.size() == 0) begin
            $display("imu_fuzz_deadzone_filter_core_tb OK");
        end else begin
            if (predicted_words.size() != 0)
                $display("%0t: %0d expected words never arrived", $time, predicted_words.size());
            $display("imu_fuzz_deadzone_filter_core_tb NOT OK");
        end
        $finish;
    end

endmodule
